// ===== design/umf_pkg.sv =====
// shared types and constants for the unsharp mask frame block
`default_nettype none
package umf_pkg;
    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int DimW      = $clog2(MaxWidth) + 1;
    localparam int AddrW     = $clog2(MaxWidth * MaxHeight);
    localparam int CntW      = AddrW + 1;

    localparam logic [2:0] REG_RADIUS    = 3'd0;
    localparam logic [2:0] REG_AMOUNT    = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_WIDTH     = 3'd3;
    localparam logic [2:0] REG_HEIGHT    = 3'd4;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel_value;
    } umf_in_t;

    typedef struct packed {
        logic [7:0] sharpened_pixel;
        logic       last_pixel;
    } umf_out_t;

    function automatic logic [4:0] umf_gain(input logic [4:0] radius);
        logic [4:0] g;
        unique case (radius)
            5'd0:  g = 5'd16;
            5'd1:  g = 5'd14;
            5'd2:  g = 5'd10;
            5'd3:  g = 5'd8;
            5'd4:  g = 5'd6;
            5'd5:  g = 5'd5;
            5'd6:  g = 5'd5;
            5'd7:  g = 5'd4;
            5'd8:  g = 5'd3;
            5'd9:  g = 5'd3;
            5'd10: g = 5'd3;
            5'd11: g = 5'd3;
            5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17: g = 5'd2;
            default: g = 5'd1;
        endcase
        return g;
    endfunction
endpackage
`default_nettype wire

// ===== design/unsharp_mask_frame.sv =====
// top level of the unsharp mask frame sharpener
`default_nettype none
// Loads one gray frame (func 0) in raster order, then blurs a copy with four
// recursive passes (down, right, up, left) and gives sharpened pixels on reads
// (func 1), one result per read, one strobe cycle each; the receiver cannot
// stall. A load goes through accept and memory write; a read goes through
// accept, memory read, difference and multiply (skipped when no frame is
// ready), clamp and result strobe. The load that completes a frame starts a
// copy sweep (read, then write) then four blur passes, each pixel going
// through the read, wait and update steps of the single port blur memory.
// busy is high during all of this. Config writes are taken at any time.
module unsharp_mask_frame (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire umf_pkg::umf_in_t    in_data,
    output logic                     strobe,
    output umf_pkg::umf_out_t        out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [11:0]         cfg_data
);
    localparam int AW = umf_pkg::AddrW;
    localparam int CW = umf_pkg::CntW;
    localparam int DW = umf_pkg::DimW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_COPYR = 4'd2;
    localparam logic [3:0] S_COPYW = 4'd3;
    localparam logic [3:0] S_BRD   = 4'd4;
    localparam logic [3:0] S_BWAIT = 4'd5;
    localparam logic [3:0] S_BUPD  = 4'd6;
    localparam logic [3:0] S_RRD   = 4'd7;
    localparam logic [3:0] S_RMUL  = 4'd8;
    localparam logic [3:0] S_ROUT  = 4'd9;
    localparam logic [3:0] S_RWAIT = 4'd10;

    // configuration registers
    logic [4:0]  radius_reg;
    logic [11:0] amount_reg;
    logic [8:0]  thresh_reg;
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 5'd8;
            amount_reg <= 12'd26;
            thresh_reg <= 9'd1;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                umf_pkg::REG_RADIUS:    radius_reg <= cfg_data[4:0];
                umf_pkg::REG_AMOUNT:    amount_reg <= cfg_data;
                umf_pkg::REG_THRESHOLD: thresh_reg <= cfg_data[8:0];
                umf_pkg::REG_WIDTH:     width_reg  <= cfg_data[8:0];
                umf_pkg::REG_HEIGHT:    height_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // clamped dimensions
    logic [DW-1:0] w_use, h_use;
    always_comb
    begin
        w_use = (width_reg == 9'd0) ? DW'(1)
              : ((width_reg > 9'(umf_pkg::MaxWidth)) ? DW'(umf_pkg::MaxWidth) : DW'(width_reg));
        h_use = (height_reg == 9'd0) ? DW'(1)
              : ((height_reg > 9'(umf_pkg::MaxHeight)) ? DW'(umf_pkg::MaxHeight)
                 : DW'(height_reg));
    end
    logic [CW-1:0] total_now;
    assign total_now = CW'(w_use) * CW'(h_use);

    // frame stores
    logic [7:0] orig_mem [0:(1<<AW)-1];
    logic [7:0] blur_mem [0:(1<<AW)-1];

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] load_cnt_reg, read_cnt_reg, total_reg;
    logic          ready_reg;
    logic [7:0]    pix_reg;
    // blur sweep: pass, line, position along the line
    logic [1:0]    pass_reg;
    logic [DW-1:0] line_reg, pos_reg, wl_reg, hl_reg;
    logic [4:0]    gain_reg;
    logic [11:0]   acc_reg;
    logic [CW-1:0] sweep_reg;

    // memory ports
    logic          o_we, b_we;
    logic [AW-1:0] o_waddr, o_raddr, b_addr;
    logic [7:0]    o_wdata, b_wdata, o_q, b_q;

    always_ff @(posedge clk)
    begin
        if (o_we)
            orig_mem[o_waddr] <= o_wdata;
        o_q <= orig_mem[o_raddr];
    end
    always_ff @(posedge clk)
    begin
        if (b_we)
            blur_mem[b_addr] <= b_wdata;
        b_q <= blur_mem[b_addr];
    end

    // address of current blur position
    logic [DW-1:0] row, col, line_len, line_cnt;
    logic [CW-1:0] blur_idx;
    always_comb
    begin
        line_len = pass_reg[0] ? wl_reg : hl_reg;
        line_cnt = pass_reg[0] ? hl_reg : wl_reg;
        unique case (pass_reg)
            2'd0: begin col = line_reg; row = pos_reg; end
            2'd1: begin row = line_reg; col = pos_reg; end
            2'd2: begin col = line_reg; row = hl_reg - DW'(1) - pos_reg; end
            default: begin row = line_reg; col = wl_reg - DW'(1) - pos_reg; end
        endcase
        blur_idx = CW'(row) * CW'(wl_reg) + CW'(col);
    end

    // blur update: acc += (16*px - acc) * gain / 16, truncated toward zero
    logic signed [13:0] bdiff;
    logic signed [19:0] bprod;
    logic signed [19:0] bstep;
    logic [11:0]        acc_new;
    always_comb
    begin
        bdiff   = $signed({2'b00, b_q, 4'b0000}) - $signed({2'b00, acc_reg});
        bprod   = 20'(bdiff) * $signed({15'd0, gain_reg});
        bstep   = (bprod < 0) ? -((-bprod) >>> 4) : (bprod >>> 4);
        acc_new = 12'(20'(acc_reg) + bstep);
    end

    // sharpening, split into a registered difference and multiply, then scale and clamp
    logic [7:0]         orig_reg;
    logic               last_reg;
    logic signed [8:0]  sdiff;
    logic [8:0]         smag;
    logic signed [21:0] sprod_reg;
    logic signed [21:0] sq;
    // wide enough for orig plus the largest scaled difference
    logic signed [13:0] sval;
    always_comb
    begin
        sdiff = $signed({1'b0, o_q}) - $signed({1'b0, b_q});
        smag  = sdiff[8] ? 9'(-sdiff) : 9'(sdiff);
        sq    = (sprod_reg < 0) ? -((-sprod_reg) >>> 8) : (sprod_reg >>> 8);
        sval  = $signed({6'b000000, orig_reg}) + 14'(sq);
    end

    logic pass_end, line_end;
    assign line_end = (pos_reg == line_len - DW'(1));
    assign pass_end = (line_reg == line_cnt - DW'(1));

    always_comb
    begin
        state_next = state_reg;
        o_we = 1'b0; o_waddr = load_cnt_reg[AW-1:0]; o_wdata = pix_reg;
        o_raddr = sweep_reg[AW-1:0];
        b_we = 1'b0; b_addr = blur_idx[AW-1:0]; b_wdata = 8'(acc_new >> 4);
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = in_data.func ? S_RRD : S_LOAD;
            S_LOAD:
            begin
                o_we = 1'b1;
                state_next = (load_cnt_reg + CW'(1) >= total_now) ? S_COPYR : S_IDLE;
            end
            S_COPYR: state_next = S_COPYW;
            S_COPYW:
            begin
                b_we = 1'b1; b_addr = sweep_reg[AW-1:0]; b_wdata = o_q;
                state_next = (sweep_reg + CW'(1) >= total_reg) ? S_BRD : S_COPYR;
            end
            S_BRD:   state_next = S_BWAIT;
            S_BWAIT: state_next = S_BUPD;
            S_BUPD:
            begin
                b_we = (pos_reg != '0);
                if (line_end && pass_end && pass_reg == 2'd3)
                    state_next = S_IDLE;
                else
                    state_next = S_BRD;
            end
            S_RRD:
            begin
                o_raddr = read_cnt_reg[AW-1:0];
                b_addr = read_cnt_reg[AW-1:0];
                state_next = ready_reg ? S_RMUL : S_ROUT;
            end
            S_RMUL:  state_next = S_ROUT;
            S_ROUT:  state_next = S_RWAIT;
            S_RWAIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            load_cnt_reg <= '0;
            read_cnt_reg <= '0;
            total_reg    <= '0;
            ready_reg    <= 1'b0;
            strobe       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            strobe    <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (start && !in_data.func && ready_reg)
                    begin
                        ready_reg    <= 1'b0;
                        load_cnt_reg <= '0;
                        read_cnt_reg <= '0;
                    end
                S_LOAD:
                    if (load_cnt_reg + CW'(1) >= total_now)
                    begin
                        total_reg    <= total_now;
                        load_cnt_reg <= '0;
                        read_cnt_reg <= '0;
                    end
                    else
                        load_cnt_reg <= load_cnt_reg + CW'(1);
                S_BUPD:
                    if (state_next == S_IDLE)
                        ready_reg <= 1'b1;
                S_ROUT:
                begin
                    strobe <= 1'b1;
                    if (ready_reg)
                    begin
                        if (read_cnt_reg + CW'(1) >= total_reg)
                        begin
                            ready_reg    <= 1'b0;
                            read_cnt_reg <= '0;
                            load_cnt_reg <= '0;
                        end
                        else
                            read_cnt_reg <= read_cnt_reg + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            pix_reg <= in_data.pixel_value;
        if (state_reg == S_LOAD)
        begin
            sweep_reg <= '0;
            wl_reg    <= w_use;
            hl_reg    <= h_use;
            gain_reg  <= umf_pkg::umf_gain(radius_reg);
        end
        if (state_reg == S_COPYW)
        begin
            sweep_reg <= sweep_reg + CW'(1);
            pass_reg  <= 2'd0;
            line_reg  <= '0;
            pos_reg   <= '0;
        end
        if (state_reg == S_BUPD)
        begin
            // first pixel of each line seeds the accumulator
            acc_reg <= (pos_reg == '0) ? {b_q, 4'b0000} : acc_new;
            if (line_end)
            begin
                pos_reg <= '0;
                if (pass_end)
                begin
                    line_reg <= '0;
                    pass_reg <= pass_reg + 2'd1;
                end
                else
                    line_reg <= line_reg + DW'(1);
            end
            else
                pos_reg <= pos_reg + DW'(1);
        end
        if (state_reg == S_RMUL)
        begin
            orig_reg  <= o_q;
            sprod_reg <= $signed({10'd0, amount_reg})
                       * 22'(((({1'b0, smag, 1'b0} < {2'b00, thresh_reg}) ? 9'sd0 : sdiff)));
            last_reg  <= (read_cnt_reg + CW'(1) >= total_reg);
        end
        if (state_reg == S_RRD)
        begin
            orig_reg  <= 8'd0;
            sprod_reg <= '0;
            last_reg  <= 1'b0;
        end
        if (state_reg == S_ROUT)
        begin
            out_data.last_pixel <= last_reg;
            out_data.sharpened_pixel <= sval[13] ? 8'd0
                                      : ((sval > 14'sd255) ? 8'd255 : sval[7:0]);
        end
    end
endmodule
`default_nettype wire

// ===== design/umf_checker.sv =====
// port-level checks for the unsharp mask frame block
`default_nettype none
module umf_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              strobe,
    input wire umf_pkg::umf_out_t out_data
);
    // a transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    // a result comes only from a busy block
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy)) else $error("strobe while idle");
    // strobes are single cycle
    a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe) else $error("strobe too long");
    // results carry no unknown bits
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !$isunknown(out_data))
        else $error("unknown result");
endmodule
bind unsharp_mask_frame umf_checker u_umf_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .strobe(strobe), .out_data(out_data)
);
`default_nettype wire
